[rtl/prq_pkg.sv]
// Shared types and constants for the priority ready queue scheduler.
// No dependencies; imported by every module of the block.
package prq_pkg;

	localparam int TASK_COUNT = 16;
	localparam int PRIO_BITS  = 8;
	localparam int SLOT_W     = 4;
	localparam int LINK_W     = 5;
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(TASK_COUNT);
	localparam logic [SLOT_W-1:0] IDLE_SLOT = '0;

	// operation codes on the request channel
	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_END    = 2'd1;
	localparam logic [1:0] OP_SCHED  = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// status codes on the response channel
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_END_IDLE = 2'd2;

	typedef struct packed {
		logic [1:0]           operation;
		logic [PRIO_BITS-1:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] task_id;
		logic [SLOT_W-1:0] current_task;
		logic              preempted;
		logic              queue_empty;
	} rsp_t;

	typedef enum logic [1:0] {
		K_CREATE,
		K_END,
		K_SCHED,
		K_NOP
	} cmd_kind_t;

	// classified command handed from front to back
	typedef struct packed {
		cmd_kind_t            kind;
		logic [PRIO_BITS-1:0] prio;
	} cmd_t;

endpackage

[rtl/prq_front.sv]
// Front end: accepts requests, decodes the operation, buffers two commands.
// Depends on prq_pkg.
module prq_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  prq_pkg::req_t req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output prq_pkg::cmd_t cmd
);
	import prq_pkg::*;

	cmd_t       buf_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       push;
	logic       pop;

	// operation decode
	always_comb begin
		dec.prio = req.priority_req;
		case (req.operation)
			OP_CREATE: dec.kind = K_CREATE;
			OP_END:    dec.kind = K_END;
			OP_SCHED:  dec.kind = K_SCHED;
			default:   dec.kind = K_NOP;
		endcase
	end

	assign req_ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rp_q];
	assign push      = req_valid && req_ready;
	assign pop       = cmd_valid && cmd_ready;

	// command buffer storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= dec;
		end
	end

	// buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[rtl/prq_back.sv]
// Back end: free list and priority-sorted ready queue, one command at a time.
// Depends on prq_pkg. Holds the link and priority tables as memories.
module prq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  prq_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output prq_pkg::rsp_t rsp
);
	import prq_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CFREE = 9'b000000010,
		S_CRDH  = 9'b000000100,
		S_CHEAD = 9'b000001000,
		S_WALK  = 9'b000010000,
		S_INS1  = 9'b000100000,
		S_INS2  = 9'b001000000,
		S_ERD   = 9'b010000000,
		S_NONE  = 9'b100000000
	} state_t;

	state_t               state_q;
	logic [LINK_W-1:0]    free_head_q;
	logic [LINK_W-1:0]    head_q;
	logic [LINK_W-1:0]    tail_q;
	logic [SLOT_W-1:0]    cur_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [PRIO_BITS-1:0] pr_q;
	logic [LINK_W-1:0]    p_q;
	logic [LINK_W-1:0]    n_q;
	logic [LINK_W-1:0]    nx_q;
	logic [LINK_W-1:0]    steps_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	// link memory with per-entry valid bits (unwritten entry chains to next)
	logic [LINK_W-1:0] lk_mem [TASK_COUNT];
	logic              lk_vld_q [TASK_COUNT];
	logic [LINK_W-1:0] lk_rd_q;
	logic              lk_rv_q;
	logic [SLOT_W-1:0] lk_ra_q;
	logic [SLOT_W-1:0] rd_addr;
	logic              lk_we;
	logic [SLOT_W-1:0] lk_wa;
	logic [LINK_W-1:0] lk_wd;
	logic [LINK_W-1:0] lk_raw;
	logic [LINK_W-1:0] lk_next;

	// priority memory with per-entry valid bits (unwritten entry reads zero)
	logic [PRIO_BITS-1:0] pr_mem [TASK_COUNT];
	logic                 pr_vld_q [TASK_COUNT];
	logic [PRIO_BITS-1:0] pr_rd_q;
	logic                 pr_rv_q;
	logic                 pr_we;
	logic [PRIO_BITS-1:0] pr_out;

	logic              head_empty;
	logic [LINK_W-1:0] end_head;

	assign cmd_ready  = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign head_empty = (head_q == NULL_LINK);

	// read data with reset values, links outside the pool become null
	assign lk_raw  = lk_rv_q ? lk_rd_q : ({1'b0, lk_ra_q} + LINK_W'(1));
	assign lk_next = lk_raw[LINK_W-1] ? NULL_LINK : lk_raw;
	assign pr_out  = pr_rv_q ? pr_rd_q : '0;

	// new queue head after removing the head on end
	assign end_head = (head_empty || head_q == tail_q) ? NULL_LINK : lk_next;

	// read address select
	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = (cmd.kind == K_CREATE) ? free_head_q[SLOT_W-1:0]
			                                          : head_q[SLOT_W-1:0];
			S_CHEAD: rd_addr = lk_next[SLOT_W-1:0];
			S_WALK:  rd_addr = lk_next[SLOT_W-1:0];
			default: rd_addr = head_q[SLOT_W-1:0];
		endcase
	end

	// write port select
	always_comb begin
		lk_we = 1'b0;
		lk_wa = slot_q;
		lk_wd = NULL_LINK;
		pr_we = 1'b0;
		case (state_q)
			S_CFREE: begin
				lk_we = 1'b1;
				pr_we = 1'b1;
			end
			S_CHEAD: begin
				if (pr_q < pr_out) begin
					lk_we = 1'b1;
					lk_wd = head_q;
				end
			end
			S_INS1: begin
				lk_we = 1'b1;
				lk_wd = nx_q;
			end
			S_INS2: begin
				lk_we = 1'b1;
				lk_wa = p_q[SLOT_W-1:0];
				lk_wd = {1'b0, slot_q};
			end
			S_ERD: begin
				lk_we = 1'b1;
				lk_wa = cur_q;
				lk_wd = free_head_q;
			end
			default: ;
		endcase
	end

	// table storage and registered reads
	always_ff @(posedge clk) begin
		if (lk_we) begin
			lk_mem[lk_wa] <= lk_wd;
		end
		if (pr_we) begin
			pr_mem[slot_q] <= pr_q;
		end
		lk_rd_q <= lk_mem[rd_addr];
		lk_ra_q <= rd_addr;
		pr_rd_q <= pr_mem[rd_addr];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				lk_vld_q[i] <= 1'b0;
				pr_vld_q[i] <= 1'b0;
			end
			lk_rv_q <= 1'b0;
			pr_rv_q <= 1'b0;
		end else begin
			if (lk_we) begin
				lk_vld_q[lk_wa] <= 1'b1;
			end
			if (pr_we) begin
				pr_vld_q[slot_q] <= 1'b1;
			end
			lk_rv_q <= lk_vld_q[rd_addr];
			pr_rv_q <= pr_vld_q[rd_addr];
		end
	end

	// scheduler sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= LINK_W'(1);
			head_q      <= NULL_LINK;
			tail_q      <= NULL_LINK;
			cur_q       <= IDLE_SLOT;
			rsp_valid_q <= 1'b0;
			slot_q      <= '0;
			pr_q        <= '0;
			p_q         <= NULL_LINK;
			n_q         <= NULL_LINK;
			nx_q        <= NULL_LINK;
			steps_q     <= '0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						pr_q                <= cmd.prio;
						rsp_q.task_id       <= '0;
						rsp_q.preempted     <= 1'b0;
						rsp_q.queue_empty   <= head_empty;
						case (cmd.kind)
							K_CREATE: begin
								rsp_q.current_task <= cur_q;
								if (free_head_q == NULL_LINK) begin
									rsp_q.status <= ST_FULL;
									rsp_valid_q  <= 1'b1;
								end else begin
									rsp_q.status <= ST_OK;
									slot_q       <= free_head_q[SLOT_W-1:0];
									state_q      <= S_CFREE;
								end
							end
							K_END: begin
								rsp_q.current_task <= cur_q;
								if (cur_q == IDLE_SLOT) begin
									rsp_q.status <= ST_END_IDLE;
									rsp_valid_q  <= 1'b1;
								end else begin
									rsp_q.status <= ST_OK;
									state_q      <= S_ERD;
								end
							end
							K_SCHED: begin
								rsp_q.status       <= ST_OK;
								cur_q              <= head_empty ? IDLE_SLOT
								                                 : head_q[SLOT_W-1:0];
								rsp_q.current_task <= head_empty ? IDLE_SLOT
								                                 : head_q[SLOT_W-1:0];
								rsp_valid_q        <= 1'b1;
							end
							default: begin
								rsp_q.status       <= ST_OK;
								rsp_q.current_task <= cur_q;
								rsp_valid_q        <= 1'b1;
							end
						endcase
					end
				end
				// pop free list, write priority, clear own link
				S_CFREE: begin
					free_head_q   <= lk_next;
					rsp_q.task_id <= slot_q;
					if (head_empty) begin
						head_q            <= {1'b0, slot_q};
						tail_q            <= {1'b0, slot_q};
						rsp_q.queue_empty <= 1'b0;
						rsp_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end else begin
						state_q <= S_CRDH;
					end
				end
				S_CRDH: begin
					state_q <= S_CHEAD;
				end
				// compare against head: preempt or start the walk
				S_CHEAD: begin
					if (pr_q < pr_out) begin
						head_q             <= {1'b0, slot_q};
						cur_q              <= slot_q;
						rsp_q.current_task <= slot_q;
						rsp_q.preempted    <= 1'b1;
						rsp_q.queue_empty  <= 1'b0;
						rsp_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end else begin
						p_q     <= head_q;
						steps_q <= '0;
						if (lk_next == NULL_LINK) begin
							nx_q    <= NULL_LINK;
							state_q <= S_INS1;
						end else begin
							n_q     <= lk_next;
							state_q <= S_WALK;
						end
					end
				end
				// one linked entry per cycle
				S_WALK: begin
					if (pr_out > pr_q) begin
						nx_q    <= n_q;
						state_q <= S_INS1;
					end else begin
						p_q     <= n_q;
						steps_q <= steps_q + LINK_W'(1);
						if (steps_q == LINK_W'(TASK_COUNT - 1) || lk_next == NULL_LINK) begin
							nx_q    <= lk_next;
							state_q <= S_INS1;
						end else begin
							n_q <= lk_next;
						end
					end
				end
				S_INS1: begin
					state_q <= S_INS2;
				end
				S_INS2: begin
					if (p_q != {1'b0, slot_q} && nx_q == NULL_LINK) begin
						tail_q <= {1'b0, slot_q};
					end
					rsp_q.queue_empty <= 1'b0;
					rsp_valid_q       <= 1'b1;
					state_q           <= S_IDLE;
				end
				// remove head, free current slot, pick next
				S_ERD: begin
					head_q      <= end_head;
					if (head_empty || head_q == tail_q || end_head == NULL_LINK) begin
						tail_q <= NULL_LINK;
					end
					free_head_q        <= {1'b0, cur_q};
					cur_q              <= (end_head == NULL_LINK) ? IDLE_SLOT
					                                              : end_head[SLOT_W-1:0];
					rsp_q.current_task <= (end_head == NULL_LINK) ? IDLE_SLOT
					                                              : end_head[SLOT_W-1:0];
					rsp_q.queue_empty  <= (end_head == NULL_LINK);
					rsp_valid_q        <= 1'b1;
					state_q            <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/priority_ready_queue_with_task_pool.sv]
// Hardware task scheduler: 16 task slots, free list and priority ready queue.
// Requests enter on req (operation, priority_req), one response leaves on rsp
// per request, in request order.
// A create on an empty queue makes the new task the head and tail; otherwise it
// reads the head, preempts when the new priority is lower in value, or walks
// the queue behind the head for the sorted insert. The insert walk reads the
// link and priority tables once per cycle through one read port each.
// One command runs at a time in the back end; a two-entry command buffer in
// the front end keeps taking requests while a response is pending.
// When rsp_ready is low the finished response holds in the output register and
// the back end waits; the front end fills up and then drops req_ready.
// Reset: slot 0 is the idle task and runs, slots 1 to 15 are free, the ready
// queue is empty and both channels come up with nothing in flight.
// Depends on prq_pkg, prq_front and prq_back.
module priority_ready_queue_with_task_pool (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  prq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output prq_pkg::rsp_t rsp
);
	import prq_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	prq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	prq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

`ifndef ASSERT_OFF
	// a rejected end leaves the idle task running
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_END_IDLE |-> rsp.current_task == IDLE_SLOT)
		else $error("rejected end with non-idle task running");

	// a preempt switches to the task just created, which sits in the queue
	a_preempt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.preempted |->
			rsp.task_id == rsp.current_task && !rsp.queue_empty && rsp.status == ST_OK)
		else $error("preempt does not match created task");

	// pool full never hands out a slot
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.task_id == '0 && !rsp.preempted)
		else $error("pool full response carries a slot");

	// a response that carries a created task shows a non-empty ready queue
	a_create_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.task_id != '0 |-> !rsp.queue_empty)
		else $error("created task missing from ready queue");
`endif

endmodule
